/* rtl/nbrq_pkg.sv */
// ----------------------------------------------------------------------------
// nbrq_pkg
// Word types and constants shared by the null bitmap rank query block and its
// checker.
// ----------------------------------------------------------------------------
package nbrq_pkg;

    localparam int COUNT_W    = 11;  // element_count register width
    localparam int POS_W      = 10;
    localparam int BIDX_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int RANK_W     = 10;
    localparam int SCAN_W     = 9;   // byte counter, covers up to 256 bytes

    localparam logic             CMD_LOAD  = 1'b0;
    localparam logic             CMD_QUERY = 1'b1;
    localparam logic [RANK_W-1:0] RANK_MAX = 10'd1023;

    typedef struct packed {
        logic              cmd;
        logic [BIDX_W-1:0] byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic [POS_W-1:0]  position;
    } t_in_word;

    typedef struct packed {
        logic              is_null;
        logic [RANK_W-1:0] nulls_before;
        logic              any_null;
        logic              out_of_range;
    } t_out_word;

endpackage

/* rtl/null_bitmap_rank_query.sv */
// Load word: written to the bitmap memory at the accepting edge if byte_index
// is below its depth. Query word: scanned over ceil(count/8) bytes, where count
// is the clamped element_count, then held in a done state until the result
// register is free; out of range skips the scan. The input stalls from a query
// until its result is written; while idle it takes a load word every cycle.
// Reset clears control state and element_count; bitmap contents are not reset.
// ----------------------------------------------------------------------------
// null_bitmap_rank_query
// Null bitmap store with per-element null test, rank count and any-null flag,
// computed by a byte-serial scan of a synchronous bitmap memory.
// ----------------------------------------------------------------------------
module null_bitmap_rank_query #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  nbrq_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output nbrq_pkg::t_out_word          o_out_word,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [nbrq_pkg::COUNT_W-1:0] i_cfg_data
);
    import nbrq_pkg::*;

    localparam int DEPTH = (MAX_ELEMENTS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    logic [BYTE_W-1:0] mem [DEPTH];

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_element_count;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SCAN_W-1:0]  r_nb, n_nb;
    logic [SCAN_W-1:0]  r_k, n_k;
    logic               r_rd_valid;
    logic [SCAN_W-1:0]  r_rd_k;
    logic [BYTE_W-1:0]  r_rd_data;
    logic [COUNT_W-1:0] r_rank, n_rank;
    logic               r_any, n_any;
    logic               r_null, n_null;
    logic               r_oor, n_oor;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               w_in_acc;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic               w_rd_en;
    logic [COUNT_W-1:0] w_count;
    logic [BYTE_W-1:0]  w_mask_cnt;
    logic [BYTE_W-1:0]  w_mask_pos;
    logic               w_last;
    logic               w_slot_free;

    function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] v);
        logic [3:0] s;
        s = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            s = s + 4'(v[b]);
        end
        return s;
    endfunction

    // lowest l elements of a byte sit in its top l bits
    function automatic logic [BYTE_W-1:0] head_mask(input logic [2:0] l);
        return ~(8'hFF >> l);
    endfunction

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_wr_en   = w_in_acc && (i_in_word.cmd == CMD_LOAD)
                       && (int'(i_in_word.byte_index) < DEPTH);
    assign w_wr_addr = AW'(i_in_word.byte_index);
    assign w_rd_en   = (r_state == ST_SCAN) && (r_k < r_nb);
    assign w_count   = (int'(r_element_count) > MAX_ELEMENTS) ?
                       COUNT_W'(MAX_ELEMENTS) : r_element_count;
    assign w_last    = r_rd_valid && (r_rd_k == r_nb - SCAN_W'(1));
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_rd_k < {1'b0, r_count[COUNT_W-1:3]}) begin
            w_mask_cnt = 8'hFF;
        end else if (r_rd_k == {1'b0, r_count[COUNT_W-1:3]}) begin
            w_mask_cnt = head_mask(r_count[2:0]);
        end else begin
            w_mask_cnt = '0;
        end
        if (r_rd_k < {2'b0, r_pos[POS_W-1:3]}) begin
            w_mask_pos = 8'hFF;
        end else if (r_rd_k == {2'b0, r_pos[POS_W-1:3]}) begin
            w_mask_pos = head_mask(r_pos[2:0]);
        end else begin
            w_mask_pos = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_nb        = r_nb;
        n_k         = r_k;
        n_rank      = r_rank;
        n_any       = r_any;
        n_null      = r_null;
        n_oor       = r_oor;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in_word.cmd == CMD_QUERY)) begin
                    n_count = w_count;
                    n_pos   = i_in_word.position;
                    n_nb    = SCAN_W'((12'(w_count) + 12'd7) >> 3);
                    n_k     = '0;
                    n_rank  = '0;
                    n_any   = 1'b0;
                    n_null  = 1'b0;
                    n_oor   = ({1'b0, i_in_word.position} >= w_count);
                    n_state = n_oor ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_rd_en) begin
                    n_k = r_k + SCAN_W'(1);
                end
                if (r_rd_valid) begin
                    n_rank = r_rank + COUNT_W'(popcount8(r_rd_data & w_mask_pos));
                    n_any  = r_any || ((r_rd_data & w_mask_cnt) != '0);
                    if (r_rd_k == {2'b0, r_pos[POS_W-1:3]}) begin
                        n_null = r_rd_data[3'd7 - r_pos[2:0]];
                    end
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_out_valid             = 1'b1;
                    n_out_word.out_of_range = r_oor;
                    n_out_word.is_null      = !r_oor && r_null;
                    n_out_word.any_null     = !r_oor && r_any;
                    if (r_oor) begin
                        n_out_word.nulls_before = '0;
                    end else if (r_rank > COUNT_W'(RANK_MAX)) begin
                        n_out_word.nulls_before = RANK_MAX;
                    end else begin
                        n_out_word.nulls_before = r_rank[RANK_W-1:0];
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_element_count <= '0;
            r_rd_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= w_rd_en;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_element_count <= i_cfg_data;
            end
        end
        r_count    <= n_count;
        r_pos      <= n_pos;
        r_nb       <= n_nb;
        r_k        <= n_k;
        r_rd_k     <= r_k;
        r_rank     <= n_rank;
        r_any      <= n_any;
        r_null     <= n_null;
        r_oor      <= n_oor;
        r_out_word <= n_out_word;
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_in_word.byte_value;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[AW'(r_k)];
        end
    end

endmodule

/* rtl/nbrq_checker.sv */
// ----------------------------------------------------------------------------
// nbrq_checker
// Port-level checks for the null bitmap rank query block.
// ----------------------------------------------------------------------------
module nbrq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input nbrq_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input nbrq_pkg::t_out_word o_out_word
);
    import nbrq_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // out of range results carry no other information
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_of_range |->
            !o_out_word.is_null && (o_out_word.nulls_before == '0)
            && !o_out_word.any_null)
        else $error("out of range result has nonzero fields");

    // a null element inside the range makes the range contain a null
    a_null_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.is_null |-> o_out_word.any_null)
        else $error("is_null set without any_null");

    // the input is not stalled in the cycle after a load word
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.cmd == CMD_LOAD) |=> !o_in_stall)
        else $error("input stalled after a load word");

    // a query word occupies the engine
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.cmd == CMD_QUERY) |=> o_in_stall)
        else $error("input not stalled after a query word");

endmodule

bind null_bitmap_rank_query nbrq_checker u_nbrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
